// File: hw/rtl/tfn_pkg.sv
// Shared constants and types for the triangle face normal pipeline.
package tfn_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int MAG_W           = 31;   // scaled magnitudes stay below 2^31
	localparam int SHIFT_W         = 6;
	localparam int SUM_W           = 64;
	localparam int LEN_W           = 32;
	localparam int SQRT_STEPS      = 32;
	localparam int UNIT_SHIFT      = 14;   // Q1.14
	localparam int DIV_STEPS       = 15;
	localparam int NORM_W          = 16;

	typedef struct packed {
		logic                      deg;
		logic [2:0]                neg;
		logic [2:0][MAG_W-1:0]     mag;
	} side_t;

endpackage

// File: hw/rtl/tfn_front.sv
// Edge vectors, cross product, length pre-scale and sum of squares.
module tfn_front #(
	parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_valid,
	input  logic [9*COORD_WIDTH-1:0]   coords,
	output logic                       out_valid,
	output logic [tfn_pkg::SUM_W-1:0]  sum,
	output tfn_pkg::side_t             side
);
	localparam int EW = COORD_WIDTH + 1;
	localparam int PW = (EW > 32) ? 32 : EW;
	localparam int CW = 2 * PW + 1;

	logic [9:1] v_s;

	logic signed [EW-1:0]        e_s1 [6];
	logic signed [PW-1:0]        e_s2 [6];
	logic signed [2*PW-1:0]      p_s3 [6];
	logic signed [CW-1:0]        c_s4 [3];
	logic [CW-1:0]               m_s5 [3];
	logic [2:0]                  neg_s5;
	logic                        deg_s5;
	logic [CW-1:0]               or_s5;
	logic [CW-1:0]               m_s6 [3];
	logic [2:0]                  neg_s6;
	logic                        deg_s6;
	logic [tfn_pkg::SHIFT_W-1:0] sh_s6;
	tfn_pkg::side_t              side_s7;
	tfn_pkg::side_t              side_s8;
	logic [2*tfn_pkg::MAG_W-1:0] sq_s8 [3];
	tfn_pkg::side_t              side_s9;
	logic [tfn_pkg::SUM_W-1:0]   sum_s9;

	logic [EW-1:0]               e_in [6];
	logic [EW-1:0]               mag_e [6];
	logic [EW-1:0]               sc_e [6];
	logic [EW-1:0]               or_e;
	logic [tfn_pkg::SHIFT_W-1:0] sh_e;
	logic signed [PW-1:0]        e_sc [6];
	logic [CW-1:0]               mag_c [3];
	logic [tfn_pkg::SHIFT_W-1:0] sh_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e_in[i] = EW'(signed'(coords[(3+i)*COORD_WIDTH +: COORD_WIDTH]))
				- EW'(signed'(coords[i*COORD_WIDTH +: COORD_WIDTH]));
			e_in[3+i] = EW'(signed'(coords[(6+i)*COORD_WIDTH +: COORD_WIDTH]))
				- EW'(signed'(coords[i*COORD_WIDTH +: COORD_WIDTH]));
		end
	end

	// edge pre-scale: common shift brings every magnitude below 2^31
	always_comb begin
		or_e = '0;
		for (int i = 0; i < 6; i++) begin
			mag_e[i] = e_s1[i][EW-1] ? EW'(-e_s1[i]) : EW'(e_s1[i]);
			or_e = or_e | mag_e[i];
		end
		sh_e = '0;
		for (int j = 0; j < EW; j++) begin
			if (j >= tfn_pkg::MAG_W && or_e[j]) sh_e = tfn_pkg::SHIFT_W'(j - tfn_pkg::MAG_W + 1);
		end
		for (int i = 0; i < 6; i++) begin
			sc_e[i] = mag_e[i] >> sh_e;
			e_sc[i] = e_s1[i][EW-1] ? -PW'(sc_e[i]) : PW'(sc_e[i]);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = c_s4[i][CW-1] ? CW'(-c_s4[i]) : CW'(c_s4[i]);
		end
		sh_c = '0;
		for (int j = 0; j < CW; j++) begin
			if (j >= tfn_pkg::MAG_W && or_s5[j]) sh_c = tfn_pkg::SHIFT_W'(j - tfn_pkg::MAG_W + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[8:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 6; i++) begin
				e_s1[i] <= e_in[i];
				e_s2[i] <= e_sc[i];
			end
			p_s3[0] <= e_s2[1] * e_s2[5];
			p_s3[1] <= e_s2[2] * e_s2[4];
			p_s3[2] <= e_s2[2] * e_s2[3];
			p_s3[3] <= e_s2[0] * e_s2[5];
			p_s3[4] <= e_s2[0] * e_s2[4];
			p_s3[5] <= e_s2[1] * e_s2[3];
			for (int i = 0; i < 3; i++) begin
				c_s4[i] <= CW'(p_s3[2*i]) - CW'(p_s3[2*i+1]);
				m_s5[i] <= mag_c[i];
				neg_s5[i] <= c_s4[i][CW-1];
				m_s6[i] <= m_s5[i];
				side_s7.mag[i] <= tfn_pkg::MAG_W'(m_s6[i] >> sh_s6);
				sq_s8[i] <= side_s7.mag[i] * side_s7.mag[i];
			end
			deg_s5 <= (c_s4[0] == '0) && (c_s4[1] == '0) && (c_s4[2] == '0);
			or_s5 <= mag_c[0] | mag_c[1] | mag_c[2];
			neg_s6 <= neg_s5;
			deg_s6 <= deg_s5;
			sh_s6 <= sh_c;
			side_s7.neg <= neg_s6;
			side_s7.deg <= deg_s6;
			side_s8 <= side_s7;
			side_s9 <= side_s8;
			sum_s9 <= tfn_pkg::SUM_W'(sq_s8[0]) + tfn_pkg::SUM_W'(sq_s8[1])
				+ tfn_pkg::SUM_W'(sq_s8[2]);
		end
	end

	assign out_valid = v_s[9];
	assign sum       = sum_s9;
	assign side      = side_s9;

endmodule

// File: hw/rtl/tfn_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module tfn_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_valid,
	input  logic [tfn_pkg::SUM_W-1:0]  x,
	input  tfn_pkg::side_t             in_side,
	output logic                       out_valid,
	output logic [tfn_pkg::LEN_W-1:0]  len,
	output tfn_pkg::side_t             out_side
);
	localparam int N  = tfn_pkg::SQRT_STEPS;
	localparam int RW = tfn_pkg::LEN_W + 3;

	logic [N-1:0]               v_s;
	logic [RW-1:0]              rem_s  [N];
	logic [tfn_pkg::LEN_W-1:0]  root_s [N];
	logic [tfn_pkg::SUM_W-1:0]  x_s    [N];
	tfn_pkg::side_t             side_s [N];

	logic [RW-1:0]              rem_d  [N];
	logic [tfn_pkg::LEN_W-1:0]  root_d [N];
	logic [tfn_pkg::SUM_W-1:0]  x_d    [N];

	always_comb begin
		logic [RW-1:0]             r;
		logic [RW-1:0]             t;
		logic [RW-1:0]             rem_p;
		logic [tfn_pkg::LEN_W-1:0] root_p;
		logic [tfn_pkg::SUM_W-1:0] x_p;
		for (int k = 0; k < N; k++) begin
			rem_p  = (k == 0) ? '0 : rem_s[(k == 0) ? 0 : k-1];
			root_p = (k == 0) ? '0 : root_s[(k == 0) ? 0 : k-1];
			x_p    = (k == 0) ? x  : x_s[(k == 0) ? 0 : k-1];
			r = {rem_p[RW-3:0], x_p[tfn_pkg::SUM_W-1 -: 2]};
			t = RW'({root_p, 2'b01});
			if (r >= t) begin
				rem_d[k]  = r - t;
				root_d[k] = {root_p[tfn_pkg::LEN_W-2:0], 1'b1};
			end else begin
				rem_d[k]  = r;
				root_d[k] = {root_p[tfn_pkg::LEN_W-2:0], 1'b0};
			end
			x_d[k] = x_p << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[N-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < N; k++) begin
				rem_s[k]  <= rem_d[k];
				root_s[k] <= root_d[k];
				x_s[k]    <= x_d[k];
				side_s[k] <= (k == 0) ? in_side : side_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign len       = root_s[N-1];
	assign out_side  = side_s[N-1];

endmodule

// File: hw/rtl/tfn_div.sv
// Rounded unit scaling of three lanes by restoring division, then sign and output register.
module tfn_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                in_valid,
	input  logic [tfn_pkg::LEN_W-1:0]           len,
	input  tfn_pkg::side_t                      in_side,
	output logic                                out_valid,
	output logic [2:0][tfn_pkg::NORM_W-1:0]     normal,
	output logic                                degenerate
);
	localparam int N  = tfn_pkg::DIV_STEPS;
	localparam int RW = tfn_pkg::LEN_W + 1;
	localparam int NW = tfn_pkg::MAG_W + tfn_pkg::UNIT_SHIFT + 1;

	logic                              v_p;
	logic [tfn_pkg::LEN_W-1:0]         len_p;
	logic [2:0][RW-1:0]                rem_p;
	logic [2:0][N-1:0]                 low_p;
	logic [2:0]                        neg_p;
	logic                              deg_p;

	logic [N-1:0]                      v_s;
	logic [tfn_pkg::LEN_W-1:0]         len_s [N];
	logic [2:0][RW-1:0]                rem_s [N];
	logic [2:0][N-1:0]                 low_s [N];
	logic [2:0][N-1:0]                 q_s   [N];
	logic [2:0]                        neg_s [N];
	logic                              deg_s [N];

	logic                              v_q;
	logic [2:0][tfn_pkg::NORM_W-1:0]   normal_q;
	logic                              deg_q;

	logic [tfn_pkg::LEN_W-1:0]         len_nz;
	logic [2:0][NW-1:0]                num;
	logic [2:0][RW-1:0]                rem_d [N];
	logic [2:0][N-1:0]                 q_d   [N];

	always_comb begin
		len_nz = (len == '0) ? tfn_pkg::LEN_W'(1) : len;
		for (int i = 0; i < 3; i++) begin
			num[i] = (NW'(in_side.mag[i]) << tfn_pkg::UNIT_SHIFT) + NW'(len_nz >> 1);
		end
	end

	// quotient fits in DIV_STEPS bits, so the top of the numerator starts below len
	always_comb begin
		logic [RW-1:0]             r;
		logic [RW-1:0]             rem_i;
		logic [N-1:0]              low_i;
		logic [N-1:0]              q_i;
		logic [tfn_pkg::LEN_W-1:0] len_i;
		for (int k = 0; k < N; k++) begin
			len_i = (k == 0) ? len_p : len_s[(k == 0) ? 0 : k-1];
			for (int i = 0; i < 3; i++) begin
				rem_i = (k == 0) ? rem_p[i] : rem_s[(k == 0) ? 0 : k-1][i];
				low_i = (k == 0) ? low_p[i] : low_s[(k == 0) ? 0 : k-1][i];
				q_i   = (k == 0) ? '0 : q_s[(k == 0) ? 0 : k-1][i];
				r = {rem_i[RW-2:0], low_i[N-1]};
				if (r >= RW'(len_i)) begin
					rem_d[k][i] = r - RW'(len_i);
					q_d[k][i]   = {q_i[N-2:0], 1'b1};
				end else begin
					rem_d[k][i] = r;
					q_d[k][i]   = {q_i[N-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
			v_s <= '0;
			v_q <= 1'b0;
		end else if (adv) begin
			v_p <= in_valid;
			v_s <= {v_s[N-2:0], v_p};
			v_q <= v_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len_p <= len_nz;
			neg_p <= in_side.neg;
			deg_p <= in_side.deg;
			for (int i = 0; i < 3; i++) begin
				rem_p[i] <= RW'(num[i] >> N);
				low_p[i] <= num[i][N-1:0];
			end
			for (int k = 0; k < N; k++) begin
				len_s[k] <= (k == 0) ? len_p : len_s[(k == 0) ? 0 : k-1];
				neg_s[k] <= (k == 0) ? neg_p : neg_s[(k == 0) ? 0 : k-1];
				deg_s[k] <= (k == 0) ? deg_p : deg_s[(k == 0) ? 0 : k-1];
				rem_s[k] <= rem_d[k];
				q_s[k]   <= q_d[k];
				for (int i = 0; i < 3; i++) begin
					low_s[k][i] <= ((k == 0) ? low_p[i] : low_s[(k == 0) ? 0 : k-1][i]) << 1;
				end
			end
			deg_q <= deg_s[N-1];
			for (int i = 0; i < 3; i++) begin
				if (deg_s[N-1]) normal_q[i] <= '0;
				else if (neg_s[N-1][i]) normal_q[i] <= -tfn_pkg::NORM_W'(q_s[N-1][i]);
				else normal_q[i] <= tfn_pkg::NORM_W'(q_s[N-1][i]);
			end
		end
	end

	assign out_valid  = v_q;
	assign normal     = normal_q;
	assign degenerate = deg_q;

endmodule

// File: hw/rtl/triangle_face_normal.sv
// Throughput: one triangle per cycle while no result waits at the output;
// 9 front stages, 32 square root stages (one root bit each) and 17 division
// stages (setup, 15 quotient bits, output register).
// The whole pipeline holds while a result waits and m_tready is low.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
module triangle_face_normal #(
	parameter  int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF,
	localparam int IN_W        = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// first_x, first_y, first_z, second_x .. second_z, third_x .. third_z, zero fill
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// normal_x, normal_y, normal_z
	output logic [47:0]      m_tdata,
	// degenerate
	output logic [0:0]       m_tuser
);
	logic                               adv;
	logic                               front_v;
	logic [tfn_pkg::SUM_W-1:0]          front_sum;
	tfn_pkg::side_t                     front_side;
	logic                               sqrt_v;
	logic [tfn_pkg::LEN_W-1:0]          sqrt_len;
	tfn_pkg::side_t                     sqrt_side;
	logic [2:0][tfn_pkg::NORM_W-1:0]    normal;
	logic                               deg;

	// advance every stage unless a result is stuck at the output
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	tfn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.coords    (s_tdata[9*COORD_WIDTH-1:0]),
		.out_valid (front_v),
		.sum       (front_sum),
		.side      (front_side)
	);

	tfn_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (front_v),
		.x         (front_sum),
		.in_side   (front_side),
		.out_valid (sqrt_v),
		.len       (sqrt_len),
		.out_side  (sqrt_side)
	);

	tfn_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (sqrt_v),
		.len        (sqrt_len),
		.in_side    (sqrt_side),
		.out_valid  (m_tvalid),
		.normal     (normal),
		.degenerate (deg)
	);

	assign m_tdata    = normal;
	assign m_tuser[0] = deg;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("degenerate result carries a nonzero normal");

	a_nondeg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata != '0)
		else $error("zero normal without degenerate flag");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) >= -16'sd16384 && $signed(m_tdata[15:0]) <= 16'sd16384
			&& $signed(m_tdata[31:16]) >= -16'sd16384 && $signed(m_tdata[31:16]) <= 16'sd16384
			&& $signed(m_tdata[47:32]) >= -16'sd16384 && $signed(m_tdata[47:32]) <= 16'sd16384))
		else $error("normal component out of unit range");

endmodule
